// ===== hdl/parsb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the point-add / range-sum block.
// No dependencies; used by the interfaces, the controller and the datapath.
package parsb_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 9;

  // request function codes
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // adder operand selects
  typedef enum logic [1:0] {
    A_ACC,
    A_BP,
    A_IP
  } a_sel_e;

  typedef enum logic [1:0] {
    B_VAL,
    B_BP,
    B_IP
  } b_sel_e;

  // controller to datapath strobes
  typedef struct packed {
    logic   in_ld;
    logic   bp_rd_en;
    logic   ip_rd_en;
    logic   bp_wr_en;
    logic   ip_wr_en;
    logic   wr_zero;
    a_sel_e a_sel;
    b_sel_e b_sel;
    logic   sub;
    logic   acc_ld;
    logic   out_ld;
  } ctl_t;

endpackage

// ===== hdl/parsb_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results.
// Depends on parsb_pkg for field widths.
interface parsb_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 func;
  logic [parsb_pkg::IDX_W-1:0]          first_index;
  logic [parsb_pkg::IDX_W-1:0]          end_index;
  logic signed [parsb_pkg::DATA_W-1:0]  value;

  modport source (output valid, func, first_index, end_index, value, input ready);
  modport sink   (input valid, func, first_index, end_index, value, output ready);
endinterface

interface parsb_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [parsb_pkg::DATA_W-1:0]  range_sum;

  modport source (output valid, range_sum, input ready);
  modport sink   (input valid, range_sum, output ready);
endinterface

// ===== hdl/parsb_dp.sv =====
`timescale 1ns / 1ps
// Datapath: block and inner prefix memories, the shared adder/subtractor,
// accumulator and result register. Depends on parsb_pkg; driven by parsb_ctrl.
module parsb_dp #(
  parameter int ENTRIES     = 256,
  parameter int BLOCK_COUNT = 16
) (
  input  logic                                   clk_i,
  input  parsb_pkg::ctl_t                        ctl_i,
  input  logic signed [parsb_pkg::DATA_W-1:0]    value_i,
  input  logic [$clog2(BLOCK_COUNT+1)-1:0]       bp_raddr_i,
  input  logic [$clog2(BLOCK_COUNT+1)-1:0]       bp_waddr_i,
  input  logic [$clog2(ENTRIES+1)-1:0]           ip_raddr_i,
  input  logic [$clog2(ENTRIES+1)-1:0]           ip_waddr_i,
  output logic signed [parsb_pkg::DATA_W-1:0]    range_sum_o
);
  import parsb_pkg::*;

  logic [DATA_W-1:0] bp_mem [BLOCK_COUNT+1];
  logic [DATA_W-1:0] ip_mem [ENTRIES+1];

  logic [DATA_W-1:0] bp_rd_q, ip_rd_q;
  logic [DATA_W-1:0] val_q, acc_q, out_q;
  logic [DATA_W-1:0] opa, opb, sum, wdata;

  // operand selection
  always_comb begin
    case (ctl_i.a_sel)
      A_ACC:   opa = acc_q;
      A_BP:    opa = bp_rd_q;
      A_IP:    opa = ip_rd_q;
      default: opa = acc_q;
    endcase
    case (ctl_i.b_sel)
      B_VAL:   opb = val_q;
      B_BP:    opb = bp_rd_q;
      B_IP:    opb = ip_rd_q;
      default: opb = val_q;
    endcase
  end

  // the one shared adder; subtract by inverting and carrying in
  assign sum   = opa + (opb ^ {DATA_W{ctl_i.sub}}) + {{(DATA_W-1){1'b0}}, ctl_i.sub};
  assign wdata = ctl_i.wr_zero ? '0 : sum;

  // block prefix memory
  always_ff @(posedge clk_i) begin
    if (ctl_i.bp_wr_en) bp_mem[bp_waddr_i] <= wdata;
    if (ctl_i.bp_rd_en) bp_rd_q <= bp_mem[bp_raddr_i];
  end

  // inner prefix memory
  always_ff @(posedge clk_i) begin
    if (ctl_i.ip_wr_en) ip_mem[ip_waddr_i] <= wdata;
    if (ctl_i.ip_rd_en) ip_rd_q <= ip_mem[ip_raddr_i];
  end

  // operand, accumulator and result registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.in_ld)  val_q <= $unsigned(value_i);
    if (ctl_i.acc_ld) acc_q <= sum;
    if (ctl_i.out_ld) out_q <= sum;
  end

  assign range_sum_o = $signed(out_q);

endmodule

// ===== hdl/parsb_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer: clearing pass, read-modify-write walks for adds, four-step
// query sequence and result handshake. Depends on parsb_pkg; drives parsb_dp.
module parsb_ctrl #(
  parameter int ENTRIES     = 256,
  parameter int BLOCK_BITS  = 4,
  parameter int BLOCK_COUNT = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               func_i,
  input  logic [parsb_pkg::IDX_W-1:0]        first_i,
  input  logic [parsb_pkg::IDX_W-1:0]        end_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output parsb_pkg::ctl_t                    ctl_o,
  output logic [$clog2(BLOCK_COUNT+1)-1:0]   bp_raddr_o,
  output logic [$clog2(BLOCK_COUNT+1)-1:0]   bp_waddr_o,
  output logic [$clog2(ENTRIES+1)-1:0]       ip_raddr_o,
  output logic [$clog2(ENTRIES+1)-1:0]       ip_waddr_o
);
  import parsb_pkg::*;

  localparam int MAXD = (ENTRIES > BLOCK_COUNT) ? ENTRIES : BLOCK_COUNT;
  localparam int CW   = $clog2(MAXD + 2);
  localparam int IXW  = (CW > IDX_W + 1) ? CW : IDX_W + 1;
  localparam int AWI  = $clog2(ENTRIES + 1);
  localparam int AWB  = $clog2(BLOCK_COUNT + 1);
  localparam logic [IXW-1:0] ENT_X  = IXW'(ENTRIES);
  localparam logic [IXW-1:0] BLK_X  = IXW'(BLOCK_COUNT);
  localparam logic [IXW-1:0] MAXD_X = IXW'(MAXD);
  localparam logic [IXW-1:0] BMASK  = IXW'((1 << BLOCK_BITS) - 1);
  localparam logic [IXW-1:0] ONE_X  = IXW'(1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ASTART,
    ST_BWALK,
    ST_IWALK,
    ST_QA,
    ST_QB,
    ST_QC,
    ST_QD
  } state_e;

  state_e            state_q, state_d;
  logic [IXW-1:0]    cur_q, cur_d, last_q, last_d, wa_q, wa_d;
  logic              wpend_q, wpend_d;
  logic              out_valid_q, out_valid_d;
  logic [IDX_W-1:0]  first_q, first_d, end_q, end_d;

  logic [IXW-1:0]    pos_x, end_x, pf, pe, bf, be;
  logic [IXW-1:0]    blk_next, i_first, i_last;
  logic              i_any, more, in_acc;

  // saturate a query index to the table end
  function automatic logic [IXW-1:0] sat_pos(input logic [IXW-1:0] p);
    sat_pos = (p > ENT_X) ? ENT_X : p;
  endfunction

  // block of a saturated index, clipped to the last block prefix
  function automatic logic [IXW-1:0] blk_of(input logic [IXW-1:0] p);
    logic [IXW-1:0] b;
    b = p >> BLOCK_BITS;
    blk_of = (b > BLK_X) ? BLK_X : b;
  endfunction

  // index arithmetic on the captured request
  always_comb begin
    pos_x    = {{(IXW-IDX_W){1'b0}}, first_q};
    end_x    = {{(IXW-IDX_W){1'b0}}, end_q};
    pf       = sat_pos(pos_x);
    pe       = sat_pos(end_x);
    bf       = blk_of(pf);
    be       = blk_of(pe);
    blk_next = (pos_x >> BLOCK_BITS) + ONE_X;
    i_first  = pos_x + ONE_X;
    i_last   = ((pos_x | BMASK) > ENT_X) ? ENT_X : (pos_x | BMASK);
    i_any    = (i_first <= i_last);
    more     = (cur_q <= last_q);
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // next state, counters and datapath strobes
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    last_d      = last_q;
    wa_d        = wa_q;
    wpend_d     = wpend_q;
    first_d     = first_q;
    end_d       = end_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    ctl_o       = '0;
    ctl_o.a_sel = A_ACC;
    ctl_o.b_sel = B_VAL;
    bp_raddr_o  = cur_q[AWB-1:0];
    ip_raddr_o  = cur_q[AWI-1:0];
    bp_waddr_o  = wa_q[AWB-1:0];
    ip_waddr_o  = wa_q[AWI-1:0];

    case (state_q)
      ST_CLEAR: begin
        ctl_o.wr_zero  = 1'b1;
        ctl_o.bp_wr_en = (cur_q <= BLK_X);
        ctl_o.ip_wr_en = (cur_q <= ENT_X);
        bp_waddr_o     = cur_q[AWB-1:0];
        ip_waddr_o     = cur_q[AWI-1:0];
        cur_d          = cur_q + ONE_X;
        if (cur_q == MAXD_X) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        ctl_o.in_ld = in_acc;
        if (in_acc) begin
          first_d = first_i;
          end_d   = end_i;
          if (func_i == FUNC_QUERY) begin
            state_d = ST_QA;
          end else if ({{(IXW-IDX_W){1'b0}}, first_i} < ENT_X) begin
            state_d = ST_ASTART;
          end
        end
      end
      ST_ASTART: begin
        wpend_d = 1'b0;
        if (blk_next <= BLK_X) begin
          cur_d   = blk_next;
          last_d  = BLK_X;
          state_d = ST_BWALK;
        end else if (i_any) begin
          cur_d   = i_first;
          last_d  = i_last;
          state_d = ST_IWALK;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_BWALK: begin
        // read ahead one entry, write back the one read last cycle
        ctl_o.bp_rd_en = more;
        ctl_o.bp_wr_en = wpend_q;
        ctl_o.a_sel    = A_BP;
        ctl_o.b_sel    = B_VAL;
        wpend_d        = more;
        wa_d           = cur_q;
        if (more) begin
          cur_d = cur_q + ONE_X;
        end else if (i_any) begin
          cur_d   = i_first;
          last_d  = i_last;
          state_d = ST_IWALK;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_IWALK: begin
        ctl_o.ip_rd_en = more;
        ctl_o.ip_wr_en = wpend_q;
        ctl_o.a_sel    = A_IP;
        ctl_o.b_sel    = B_VAL;
        wpend_d        = more;
        wa_d           = cur_q;
        if (more) cur_d = cur_q + ONE_X;
        else      state_d = ST_IDLE;
      end
      ST_QA: begin
        // fetch prefix(end) terms
        ctl_o.bp_rd_en = 1'b1;
        ctl_o.ip_rd_en = 1'b1;
        bp_raddr_o     = be[AWB-1:0];
        ip_raddr_o     = pe[AWI-1:0];
        state_d        = ST_QB;
      end
      ST_QB: begin
        // acc = prefix(end); fetch prefix(first) terms
        ctl_o.acc_ld   = 1'b1;
        ctl_o.a_sel    = A_BP;
        ctl_o.b_sel    = B_IP;
        ctl_o.bp_rd_en = 1'b1;
        ctl_o.ip_rd_en = 1'b1;
        bp_raddr_o     = bf[AWB-1:0];
        ip_raddr_o     = pf[AWI-1:0];
        state_d        = ST_QC;
      end
      ST_QC: begin
        ctl_o.acc_ld = 1'b1;
        ctl_o.a_sel  = A_ACC;
        ctl_o.b_sel  = B_BP;
        ctl_o.sub    = 1'b1;
        state_d      = ST_QD;
      end
      ST_QD: begin
        // final subtract goes into the result register once it is free
        ctl_o.a_sel = A_ACC;
        ctl_o.b_sel = B_IP;
        ctl_o.sub   = 1'b1;
        if (!out_valid_q || out_ready_i) begin
          ctl_o.out_ld = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cur_q       <= '0;
      last_q      <= '0;
      wa_q        <= '0;
      wpend_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      last_q      <= last_d;
      wa_q        <= wa_d;
      wpend_q     <= wpend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // captured request indexes
  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    end_q   <= end_d;
  end

  // a result is never loaded over one that is still waiting
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.out_ld |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten while stalled");

  // a walk never reads the entry it writes back in the same cycle
  a_ip_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_o.ip_wr_en && ctl_o.ip_rd_en) |-> (ip_waddr_o != ip_raddr_o))
    else $error("inner prefix read/write collision");

  a_bp_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_o.bp_wr_en && ctl_o.bp_rd_en) |-> (bp_waddr_o != bp_raddr_o))
    else $error("block prefix read/write collision");

  // an add past the table end leaves the block idle
  a_add_oob: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (func_i == FUNC_ADD) && ({{(IXW-IDX_W){1'b0}}, first_i} >= ENT_X))
    |=> (state_q == ST_IDLE))
    else $error("out-of-range add started a walk");

  // a result appears only at the end of a query sequence
  a_rsp_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_QD))
    else $error("result without query");

endmodule

// ===== hdl/point_add_range_sum_blocks_top.sv =====
`timescale 1ns / 1ps
// Top level of the point-add / range-sum table.
// Depends on parsb_pkg, parsb_if, parsb_ctrl and parsb_dp.
//
// Usage:
//   req_i carries requests: func = add (value added at first_index) or
//   query (sum over [first_index, end_index)). rsp_o returns one range_sum
//   per query; adds give no result. Both channels move a request on a
//   clock edge with valid and ready high.
//   Throughput: one request at a time; ready is high only while idle.
//   A query runs registered memory reads, then three passes through the
//   shared adder (states QA to QD); rsp_o.valid rises and ready returns
//   in the same cycle. An add at entry p first walks the later block
//   prefixes, then the later inner prefixes of its block, the inner walk
//   dropping out when p is the last entry of its block; each walk updates
//   one prefix a cycle as a pipelined read-modify-write through the single
//   adder, set by the one read and one write port of each prefix memory.
//   Reset: after rst_ni rises a clearing pass zeroes both memories, one
//   entry a cycle through index max(ENTRIES, BLOCK_COUNT); req_i.ready
//   stays low meanwhile.
//   Stall: a finished result waits in the output register; the next
//   request is still taken, and only a later query waits at its last step
//   until the receiver takes the earlier result.
module point_add_range_sum_blocks_top #(
  parameter int ENTRIES     = 256,
  parameter int BLOCK_BITS  = 4,
  parameter int BLOCK_COUNT = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  parsb_req_if.sink    req_i,
  parsb_rsp_if.source  rsp_o
);
  import parsb_pkg::*;

  localparam int AWI = $clog2(ENTRIES + 1);
  localparam int AWB = $clog2(BLOCK_COUNT + 1);

  ctl_t                     ctl;
  logic [AWB-1:0]           bp_raddr, bp_waddr;
  logic [AWI-1:0]           ip_raddr, ip_waddr;
  logic signed [DATA_W-1:0] range_sum;

  // sequencer
  parsb_ctrl #(
    .ENTRIES     (ENTRIES),
    .BLOCK_BITS  (BLOCK_BITS),
    .BLOCK_COUNT (BLOCK_COUNT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .func_i      (req_i.func),
    .first_i     (req_i.first_index),
    .end_i       (req_i.end_index),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .ctl_o       (ctl),
    .bp_raddr_o  (bp_raddr),
    .bp_waddr_o  (bp_waddr),
    .ip_raddr_o  (ip_raddr),
    .ip_waddr_o  (ip_waddr)
  );

  // memories and shared adder
  parsb_dp #(
    .ENTRIES     (ENTRIES),
    .BLOCK_COUNT (BLOCK_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .ctl_i       (ctl),
    .value_i     (req_i.value),
    .bp_raddr_i  (bp_raddr),
    .bp_waddr_i  (bp_waddr),
    .ip_raddr_i  (ip_raddr),
    .ip_waddr_i  (ip_waddr),
    .range_sum_o (range_sum)
  );

  assign rsp_o.range_sum = range_sum;

endmodule

// ===== dv/point_add_range_sum_blocks_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the point-add / range-sum table: directed corners, then random
// requests under random gaps and result stalls, each result checked against a prefix-sum mirror.
// Depends on parsb_pkg, parsb_if and point_add_range_sum_blocks_top.
module point_add_range_sum_blocks_top_tb;
  import parsb_pkg::*;

  localparam int ENTRIES     = 256;
  localparam int BLOCK_BITS  = 4;
  localparam int BLOCK_COUNT = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 40;

  // one pending request plus its pacing
  typedef struct {
    logic              func;
    logic [IDX_W-1:0]  first;
    logic [IDX_W-1:0]  stop;
    logic [DATA_W-1:0] value;
    int                gap;
    bit                drain;
    bit                calm;
  } req_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  parsb_req_if req_if ();
  parsb_rsp_if rsp_if ();

  point_add_range_sum_blocks_top #(
    .ENTRIES     (ENTRIES),
    .BLOCK_BITS  (BLOCK_BITS),
    .BLOCK_COUNT (BLOCK_COUNT)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // mirror of the two prefix stores
  logic [DATA_W-1:0] blk_pfx [0:BLOCK_COUNT] = '{default: '0};
  logic [DATA_W-1:0] in_pfx  [0:ENTRIES]     = '{default: '0};

  req_item_t         req_q [$];
  logic [DATA_W-1:0] sum_q [$];

  int  err_cnt     = 0;
  int  cyc_cnt     = 0;
  int  n_add       = 0;
  int  n_add_skip  = 0;
  int  n_query     = 0;
  int  n_reversed  = 0;
  int  n_saturated = 0;
  int  n_checked   = 0;
  int  idle_cnt    = 0;
  int  stall_left  = 0;
  bit  req_done    = 1'b0;
  bit  rsp_taken   = 1'b0;
  bit  rsp_calm    = 1'b0;

  // prefix over [0, p) with out-of-table positions clamped
  function automatic logic [DATA_W-1:0] table_prefix(input int unsigned p);
    int unsigned blk;
    if (p > ENTRIES) p = ENTRIES;
    blk = p >> BLOCK_BITS;
    if (blk > BLOCK_COUNT) blk = BLOCK_COUNT;
    return blk_pfx[blk] + in_pfx[p];
  endfunction

  // apply one accepted request to the mirror; queries queue their sum
  task automatic table_step(input logic func, input logic [IDX_W-1:0] fi,
                            input logic [IDX_W-1:0] ei, input logic [DATA_W-1:0] val);
    int unsigned blk;
    int unsigned lim;
    if (func == FUNC_ADD) begin
      if (fi >= ENTRIES) begin
        n_add_skip++;
        return;
      end
      n_add++;
      blk = fi >> BLOCK_BITS;
      for (int unsigned x = blk + 1; x <= BLOCK_COUNT; x++) blk_pfx[x] += val;
      lim = (blk + 1) << BLOCK_BITS;
      if (lim > ENTRIES + 1) lim = ENTRIES + 1;
      for (int unsigned y = fi + 1; y < lim; y++) in_pfx[y] += val;
    end else begin
      n_query++;
      if (fi > ei) n_reversed++;
      if (fi > ENTRIES || ei > ENTRIES) n_saturated++;
      sum_q.push_back(table_prefix(ei) - table_prefix(fi));
    end
  endtask

  task automatic push_req(input logic func, input int fi, input int ei,
                          input logic [DATA_W-1:0] val, input int gap, input bit drain,
                          input bit calm);
    req_item_t it;
    it.func  = func;
    it.first = fi[IDX_W-1:0];
    it.stop  = ei[IDX_W-1:0];
    it.value = val;
    it.gap   = gap;
    it.drain = drain;
    it.calm  = calm;
    req_q.push_back(it);
  endtask

  // request driver: changes on the falling edge, holds until accepted
  always @(negedge clk_i) begin : req_driver
    req_item_t cur;
    if (rst_ni) begin
      if (!req_if.valid || req_done) begin
        if (req_q.size() == 0) begin
          req_if.valid <= 1'b0;
        end else if (idle_cnt < req_q[0].gap) begin
          idle_cnt++;
          req_if.valid <= 1'b0;
        end else if (req_q[0].drain && sum_q.size() != 0) begin
          // hold off until every outstanding sum is back
          req_if.valid <= 1'b0;
        end else begin
          cur = req_q.pop_front();
          idle_cnt = 0;
          req_if.valid       <= 1'b1;
          req_if.func        <= cur.func;
          req_if.first_index <= cur.first;
          req_if.end_index   <= cur.stop;
          req_if.value       <= cur.value;
          rsp_calm           <= cur.calm;
        end
      end
    end
  end

  // result ready: random stall after each taken result, none for calm requests
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rsp_taken) stall_left = rsp_calm ? 0 : $urandom_range(0, 11);
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // monitor: check results first, then fold in the accepted request
  always @(posedge clk_i) begin : monitor
    logic [DATA_W-1:0] want;
    req_done  <= req_if.valid && req_if.ready;
    rsp_taken <= rsp_if.valid && rsp_if.ready;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (sum_q.size() == 0) begin
        $error("range_sum: result with no query waiting, expected none, actual %0d",
               rsp_if.range_sum);
        err_cnt++;
      end else begin
        want = sum_q.pop_front();
        n_checked++;
        if (rsp_if.range_sum !== want) begin
          $error("range_sum mismatch: expected %0d, actual %0d", $signed(want),
                 rsp_if.range_sum);
          err_cnt++;
        end
      end
    end
    if (rst_ni && req_if.valid && req_if.ready)
      table_step(req_if.func, req_if.first_index, req_if.end_index, req_if.value);
  end

  // watchdog
  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("point_add_range_sum_blocks_top_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int          fi;
    int          ei;
    logic        fn;
    logic [31:0] val;
    bit          calm;

    req_if.valid       = 1'b0;
    req_if.func        = FUNC_ADD;
    req_if.first_index = '0;
    req_if.end_index   = '0;
    req_if.value       = '0;
    rsp_if.ready       = 1'b0;
    rst_ni             = 1'b0;

    // directed corners
    push_req(FUNC_QUERY, 0, 256, 32'h0, 0, 0, 1);          // empty table
    push_req(FUNC_ADD, 0, 0, 32'h7FFF_FFFF, 0, 0, 1);
    push_req(FUNC_ADD, 255, 511, 32'h8000_0000, 0, 0, 1);
    push_req(FUNC_ADD, 256, 0, 32'd123, 3, 0, 1);          // out of range, dropped
    push_req(FUNC_ADD, 511, 511, 32'hFFFF_FFFF, 0, 0, 1);  // out of range, dropped
    push_req(FUNC_ADD, 15, 0, 32'hFFFF_FFFF, 1, 0, 1);
    push_req(FUNC_ADD, 16, 0, 32'd1, 0, 0, 1);
    push_req(FUNC_ADD, 128, 0, 32'h5555_AAAA, 0, 0, 1);
    push_req(FUNC_ADD, 170, 341, 32'hAAAA_5555, 2, 0, 1);
    push_req(FUNC_QUERY, 0, 256, 32'hFFFF_FFFF, 0, 1, 1);  // after a full drain
    push_req(FUNC_QUERY, 0, 1, 32'h0, 0, 0, 1);
    push_req(FUNC_QUERY, 255, 256, 32'h0, 0, 0, 1);
    push_req(FUNC_QUERY, 0, 16, 32'h0, 0, 0, 1);
    push_req(FUNC_QUERY, 15, 17, 32'h0, 0, 0, 1);
    push_req(FUNC_QUERY, 256, 511, 32'h0, 0, 0, 1);        // both past the table
    push_req(FUNC_QUERY, 511, 0, 32'h0, 0, 0, 1);          // reversed and clamped
    push_req(FUNC_QUERY, 100, 3, 32'h0, 4, 0, 1);          // reversed
    push_req(FUNC_QUERY, 0, 0, 32'h0, 0, 0, 1);
    push_req(FUNC_QUERY, 256, 256, 32'h0, 0, 0, 1);
    push_req(FUNC_QUERY, 341, 170, 32'h8000_0000, 0, 0, 1);
    push_req(FUNC_QUERY, 128, 129, 32'h7FFF_FFFF, 0, 0, 1);

    // random phases, two of them with no request gaps or result stalls
    for (int ph = 0; ph < 5; ph++) begin
      calm = (ph == 0 || ph == 3);
      for (int n = 0; n < 100; n++) begin
        fn = ($urandom_range(0, 99) < 50) ? FUNC_ADD : FUNC_QUERY;
        fi = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 511) : $urandom_range(0, 256);
        ei = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 511) : $urandom_range(0, 256);
        case ($urandom_range(0, 9))
          0: val = 32'h7FFF_FFFF;
          1: val = 32'h8000_0000;
          2: val = 32'hFFFF_FFFF;
          3: val = $urandom_range(0, 15);
          default: val = $urandom();
        endcase
        push_req(fn, fi, ei, val, calm ? 0 : $urandom_range(0, 11), n == 50, calm);
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // wait out stimulus, outstanding sums, then pipeline tail
    while (req_q.size() != 0 || req_if.valid) @(posedge clk_i);
    while (sum_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (sum_q.size() != 0) begin
      $error("range_sum: %0d expected results never arrived", sum_q.size());
      err_cnt++;
    end

    $display("covered %0d adds (%0d out of range), %0d queries (%0d reversed, %0d clamped)",
             n_add, n_add_skip, n_query, n_reversed, n_saturated);
    $display("%0d sums compared over %0d cycles with random gaps and stalls",
             n_checked, cyc_cnt);
    if (err_cnt == 0) begin
      $display("point_add_range_sum_blocks_top_tb: done, clean");
    end else begin
      $display("point_add_range_sum_blocks_top_tb: done, errors");
    end
    $finish;
  end

endmodule
